// ===== rtl/core/cfr_pkg.sv =====
package cfr_pkg;

  localparam int CFR_FRAC_BITS = 16;
  localparam int CFR_WORD_BITS = 32;

  typedef enum logic [1:0] {
    MODE_ANALYTIC = 2'd0,
    MODE_LINEAR   = 2'd1,
    MODE_SQRT     = 2'd2,
    MODE_QUART    = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZDIV = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_MIN   = 2'd1;
  localparam logic [1:0] CFG_PARAM = 2'd2;
  localparam logic [1:0] CFG_LIMIT = 2'd3;

  localparam logic [31:0] MIN_RADIUS_RST  = 32'h0001_0000;
  localparam logic [31:0] SHAPE_PARAM_RST = 32'h0001_0000;
  localparam logic [31:0] CURV_LIMIT_RST  = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] curvature;
    logic        [31:0] elem_size;
  } in_t;

  typedef struct packed {
    logic [31:0] radius;
    logic [1:0]  status;
  } out_t;

endpackage

// ===== rtl/core/cfr_div_cell.sv =====
module cfr_div_cell #(
  parameter int WORD_W = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_i,
  input  logic [WORD_W-1:0] rem_i,
  input  logic [WORD_W-1:0] b_i,
  input  logic [WORD_W-1:0] num_i,
  input  logic [WORD_W-1:0] q_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  output logic [WORD_W-1:0] rem_o,
  output logic [WORD_W-1:0] b_o,
  output logic [WORD_W-1:0] num_o,
  output logic [WORD_W-1:0] q_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [WORD_W:0]   trial;
  logic              take;
  logic [WORD_W-1:0] rem_nxt, num_nxt, q_nxt;
  logic              v_r;
  logic [WORD_W-1:0] rem_r, b_r, num_r, q_r;
  logic [SIDE_W-1:0] side_r;

  // one quotient bit: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial   = {rem_i, num_i[WORD_W-1]};
    take    = trial >= {1'b0, b_i};
    rem_nxt = take ? WORD_W'(trial - {1'b0, b_i}) : trial[WORD_W-1:0];
    num_nxt = {num_i[WORD_W-2:0], 1'b0};
    q_nxt   = {q_i[WORD_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    b_r    <= b_i;
    num_r  <= num_nxt;
    q_r    <= q_nxt;
    side_r <= side_i;
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign b_o    = b_r;
  assign num_o  = num_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

// ===== rtl/core/cfr_div.sv =====
module cfr_div #(
  parameter int WORD_W = 32,
  parameter int FRAC_W = 16,
  parameter int NUM_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_i,
  input  logic [NUM_W-1:0]  a_i,
  input  logic [WORD_W-1:0] b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  output logic [WORD_W-1:0] q_o,
  output logic              sat_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int N_W   = NUM_W + FRAC_W;
  localparam int CMP_W = (N_W > 2 * WORD_W) ? N_W : 2 * WORD_W;

  logic [N_W-1:0] num;
  logic           ovf;

  logic              vv  [0:WORD_W];
  logic [WORD_W-1:0] rem [0:WORD_W];
  logic [WORD_W-1:0] bb  [0:WORD_W];
  logic [WORD_W-1:0] nn  [0:WORD_W];
  logic [WORD_W-1:0] qq  [0:WORD_W];
  logic [SIDE_W:0]   sd  [0:WORD_W];

  // quotient of 2^WORD_W or more (zero divisor too) saturates
  always_comb begin
    num = {a_i, {FRAC_W{1'b0}}};
    ovf = CMP_W'(num) >= (CMP_W'(b_i) << WORD_W);
  end

  assign vv[0]  = v_i;
  assign rem[0] = WORD_W'(num >> WORD_W);
  assign bb[0]  = b_i;
  assign nn[0]  = num[WORD_W-1:0];
  assign qq[0]  = '0;
  assign sd[0]  = {ovf, side_i};

  for (genvar i = 0; i < WORD_W; i++) begin : g_cell
    cfr_div_cell #(
      .WORD_W(WORD_W),
      .SIDE_W(SIDE_W + 1)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (vv[i]),
      .rem_i (rem[i]),
      .b_i   (bb[i]),
      .num_i (nn[i]),
      .q_i   (qq[i]),
      .side_i(sd[i]),
      .v_o   (vv[i+1]),
      .rem_o (rem[i+1]),
      .b_o   (bb[i+1]),
      .num_o (nn[i+1]),
      .q_o   (qq[i+1]),
      .side_o(sd[i+1])
    );
  end

  assign v_o    = vv[WORD_W];
  assign sat_o  = sd[WORD_W][SIDE_W];
  assign q_o    = sd[WORD_W][SIDE_W] ? {WORD_W{1'b1}} : qq[WORD_W];
  assign side_o = sd[WORD_W][SIDE_W-1:0];

endmodule

// ===== rtl/core/cfr_sqrt_cell.sv =====
module cfr_sqrt_cell #(
  parameter int ROOT_W = 24,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_i,
  input  logic [ROOT_W-1:0]   rem_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [2*ROOT_W-1:0] num_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                v_o,
  output logic [ROOT_W-1:0]   rem_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [2*ROOT_W-1:0] num_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic [ROOT_W+1:0]   cur, trial;
  logic                take;
  logic [ROOT_W-1:0]   rem_nxt, root_nxt;
  logic [2*ROOT_W-1:0] num_nxt;
  logic                v_r;
  logic [ROOT_W-1:0]   rem_r, root_r;
  logic [2*ROOT_W-1:0] num_r;
  logic [SIDE_W-1:0]   side_r;

  // one root digit: bring down two operand bits, try root*4+1
  always_comb begin
    cur      = {rem_i, num_i[2*ROOT_W-1 -: 2]};
    trial    = {root_i, 2'b01};
    take     = cur >= trial;
    rem_nxt  = take ? ROOT_W'(cur - trial) : cur[ROOT_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], take};
    num_nxt  = {num_i[2*ROOT_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    num_r  <= num_nxt;
    side_r <= side_i;
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign num_o  = num_r;
  assign side_o = side_r;

endmodule

// ===== rtl/core/cfr_sqrt.sv =====
module cfr_sqrt #(
  parameter int WORD_W = 32,
  parameter int FRAC_W = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  output logic [WORD_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int ROOT_W = (WORD_W + FRAC_W + 1) / 2;

  logic                vv [0:ROOT_W];
  logic [ROOT_W-1:0]   rm [0:ROOT_W];
  logic [ROOT_W-1:0]   rt [0:ROOT_W];
  logic [2*ROOT_W-1:0] nm [0:ROOT_W];
  logic [SIDE_W-1:0]   sd [0:ROOT_W];

  assign vv[0] = v_i;
  assign rm[0] = '0;
  assign rt[0] = '0;
  assign nm[0] = (2 * ROOT_W)'({a_i, {FRAC_W{1'b0}}});
  assign sd[0] = side_i;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    cfr_sqrt_cell #(
      .ROOT_W(ROOT_W),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (vv[i]),
      .rem_i (rm[i]),
      .root_i(rt[i]),
      .num_i (nm[i]),
      .side_i(sd[i]),
      .v_o   (vv[i+1]),
      .rem_o (rm[i+1]),
      .root_o(rt[i+1]),
      .num_o (nm[i+1]),
      .side_o(sd[i+1])
    );
  end

  assign v_o    = vv[ROOT_W];
  assign root_o = WORD_W'(rt[ROOT_W]);
  assign side_o = sd[ROOT_W];

endmodule

// ===== rtl/core/curvature_to_filter_radius.sv =====
// Adaptive filter radius from curvature. One item is taken on every cycle that
// start is high (busy stays low), and its result appears on out_data with the
// out_valid strobe, whatever the mode. Every item passes the rows of one-bit
// divider cells (four divisions) and two-bit root cells (two square roots).
// Results are strobed for a single cycle and cannot be held off, so the
// receiver must take them as they come. Write the configuration registers
// only while no item is in flight.
module curvature_to_filter_radius #(
  parameter int FRAC_BITS = cfr_pkg::CFR_FRAC_BITS,
  parameter int WORD_BITS = cfr_pkg::CFR_WORD_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cfr_pkg::in_t  in_data,
  output logic          out_valid,
  output cfr_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [31:0]   cfg_wdata
);

  import cfr_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int XW     = (W > 32) ? W : 32;
  localparam int QNUM_W = (F + 3 > W) ? F + 3 : W;
  localparam logic [W-1:0]      WMAX  = {W{1'b1}};
  localparam logic [QNUM_W-1:0] QFOUR = QNUM_W'(4) << F;

  typedef struct packed {
    logic         sat;
    logic         fb;
    logic         zdiv;
    logic         dk0;
    logic         neg;
    logic         sneg;
    logic [W-1:0] k;
    logic [W-1:0] h;
    logic [W-1:0] ph;
    logic [W-1:0] dkmax;
    logic [W-1:0] x;
    logic [W-1:0] y;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

  function automatic logic [W:0] qmul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [2*W-1:0] sh;
    sh = ((2 * W)'(a) * (2 * W)'(b)) >> F;
    if (|sh[2*W-1:W]) return {1'b1, WMAX};
    return {1'b0, sh[W-1:0]};
  endfunction

  function automatic logic [W:0] clampw(input logic [31:0] v);
    logic [XW-1:0] vx;
    vx = XW'(v);
    if (vx > XW'(WMAX)) return {1'b1, WMAX};
    return {1'b0, vx[W-1:0]};
  endfunction

  // configuration
  mode_t       mode_r;
  logic [31:0] min_r, par_r, lim_r;
  logic [W-1:0] cm, cp, cl;
  logic         cm_sat, cp_sat, cl_sat, cfg_sat, an;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ANALYTIC;
      min_r  <= MIN_RADIUS_RST;
      par_r  <= SHAPE_PARAM_RST;
      lim_r  <= CURV_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:  mode_r <= mode_t'(cfg_wdata[1:0]);
        CFG_MIN:   min_r  <= cfg_wdata;
        CFG_PARAM: par_r  <= cfg_wdata;
        CFG_LIMIT: lim_r  <= cfg_wdata;
        default:   mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    {cm_sat, cm} = clampw(min_r);
    {cp_sat, cp} = clampw(par_r);
    {cl_sat, cl} = clampw(lim_r);
    cfg_sat      = cm_sat | cp_sat | cl_sat;
    an           = (mode_r == MODE_ANALYTIC);
  end

  assign busy = 1'b0;

  // pipeline registers
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic s9_v_r, s10_v_r, s11_v_r, s12_v_r, out_v_r;
  ctx_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, s10_r, s11_r, s12_r;
  ctx_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt;
  ctx_t s9_nxt, s10_nxt, s11_nxt, s12_nxt;
  out_t out_r, out_nxt;

  // unit outputs
  logic             d1_v, d2_v, d3_v, d4_v, q1_v, q2_v;
  logic [W-1:0]     d1_q, d2_q, d3_q, d4_q, q1_root, q2_root;
  logic             d1_sat, d2_sat, d3_sat, d4_sat;
  logic [CTX_W-1:0] d1_side, d2_side, d3_side, d4_side, q1_side, q2_side;

  // entry: magnitude and clamp
  logic [31:0] kabs;
  logic        k_sat, h_sat;
  always_comb begin
    kabs   = in_data.curvature[31] ? $unsigned(-in_data.curvature)
                                   : $unsigned(in_data.curvature);
    s1_nxt = '0;
    {k_sat, s1_nxt.k} = clampw(kabs);
    {h_sat, s1_nxt.h} = clampw(in_data.elem_size);
    s1_nxt.sat = k_sat | h_sat;
  end

  // p*h for the root laws, p*L for the analytic law
  logic         ph_sat, pl_sat;
  logic [W-1:0] ph_val, pl_val;
  always_comb begin
    {ph_sat, ph_val} = qmul(cp, s1_r.h);
    {pl_sat, pl_val} = qmul(cp, cl);
    s2_nxt     = s1_r;
    s2_nxt.ph  = ph_val;
    s2_nxt.y   = pl_val;
    s2_nxt.sat = s1_r.sat | (an ? pl_sat : ph_sat);
    if (an && cm == '0) begin
      s2_nxt.fb   = 1'b1;
      s2_nxt.zdiv = 1'b1;
    end
  end

  cfr_div #(.WORD_W(W), .FRAC_W(F), .NUM_W(W), .SIDE_W(CTX_W)) u_div_t (
    .clk(clk), .rst_n(rst_n), .v_i(s2_v_r), .a_i(s2_r.h), .b_i(cm), .side_i(s2_r),
    .v_o(d1_v), .q_o(d1_q), .sat_o(d1_sat), .side_o(d1_side)
  );

  // (h/m)^2, (h/m)^4, 4*(h/m)^4 and its distance from p
  logic         m3_sat, m4_sat, m5_sat;
  logic [W-1:0] m3_val, m4_val;
  always_comb begin
    {m3_sat, m3_val} = qmul(d1_q, d1_q);
    s3_nxt     = ctx_t'(d1_side);
    s3_nxt.x   = m3_val;
    s3_nxt.sat = s3_nxt.sat | (an & (d1_sat | m3_sat));

    {m4_sat, m4_val} = qmul(s3_r.x, s3_r.x);
    s4_nxt     = s3_r;
    s4_nxt.x   = m4_val;
    s4_nxt.sat = s3_r.sat | (an & m4_sat);

    m5_sat       = |s4_r.x[W-1:W-2];
    s5_nxt       = s4_r;
    s5_nxt.dkmax = m5_sat ? WMAX : {s4_r.x[W-3:0], 2'b00};
    s5_nxt.sat   = s4_r.sat | (an & m5_sat);

    s6_nxt     = s5_r;
    s6_nxt.neg = s5_r.dkmax < cp;
    s6_nxt.x   = s6_nxt.neg ? cp - s5_r.dkmax : s5_r.dkmax - cp;
    if (an && s5_r.dkmax == cp) begin
      s6_nxt.fb   = 1'b1;
      s6_nxt.zdiv = 1'b1;
    end
  end

  cfr_div #(.WORD_W(W), .FRAC_W(F), .NUM_W(W), .SIDE_W(CTX_W)) u_div_b (
    .clk(clk), .rst_n(rst_n), .v_i(s6_v_r), .a_i(s6_r.y), .b_i(s6_r.x), .side_i(s6_r),
    .v_o(d2_v), .q_o(d2_q), .sat_o(d2_sat), .side_o(d2_side)
  );

  // a = b*dKmax and the signed divisor |k| + b
  ctx_t         d2_c;
  logic         am_sat, add_sat;
  logic [W-1:0] am_val;
  logic [W:0]   ksum;
  always_comb begin
    d2_c = ctx_t'(d2_side);
    {am_sat, am_val} = qmul(d2_q, d2_c.dkmax);
    ksum    = {1'b0, d2_c.k} + {1'b0, d2_q};
    add_sat = 1'b0;
    s7_nxt  = d2_c;
    s7_nxt.x    = am_val;
    s7_nxt.sneg = 1'b0;
    if (!d2_c.neg) begin
      add_sat  = ksum[W];
      s7_nxt.y = ksum[W] ? WMAX : ksum[W-1:0];
    end else if (d2_c.k >= d2_q) begin
      s7_nxt.y = d2_c.k - d2_q;
    end else begin
      s7_nxt.y    = d2_q - d2_c.k;
      s7_nxt.sneg = 1'b1;
    end
    s7_nxt.sat = d2_c.sat | (an & (d2_sat | am_sat | add_sat));

    s8_nxt = s7_r;
    if (an && s7_r.y == '0) begin
      s8_nxt.fb   = 1'b1;
      s8_nxt.zdiv = 1'b1;
    end
    if (an && (s7_r.x == '0 || s7_r.neg != s7_r.sneg)) begin
      s8_nxt.fb = 1'b1;
    end
  end

  cfr_div #(.WORD_W(W), .FRAC_W(F), .NUM_W(W), .SIDE_W(CTX_W)) u_div_dk (
    .clk(clk), .rst_n(rst_n), .v_i(s8_v_r), .a_i(s8_r.x), .b_i(s8_r.y), .side_i(s8_r),
    .v_o(d3_v), .q_o(d3_q), .sat_o(d3_sat), .side_o(d3_side)
  );

  always_comb begin
    s9_nxt     = ctx_t'(d3_side);
    s9_nxt.x   = d3_q;
    s9_nxt.sat = s9_nxt.sat | (an & d3_sat);
    if (an && d3_q == '0) begin
      s9_nxt.dk0 = 1'b1;
    end
  end

  cfr_div #(.WORD_W(W), .FRAC_W(F), .NUM_W(QNUM_W), .SIDE_W(CTX_W)) u_div_w (
    .clk(clk), .rst_n(rst_n), .v_i(s9_v_r), .a_i(QFOUR), .b_i(s9_r.x), .side_i(s9_r),
    .v_o(d4_v), .q_o(d4_q), .sat_o(d4_sat), .side_o(d4_side)
  );

  // root operand: 4/dK for the analytic law, |k| otherwise
  always_comb begin
    s10_nxt     = ctx_t'(d4_side);
    s10_nxt.x   = an ? d4_q : s10_nxt.k;
    s10_nxt.sat = s10_nxt.sat | (an & d4_sat);
  end

  cfr_sqrt #(.WORD_W(W), .FRAC_W(F), .SIDE_W(CTX_W)) u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .v_i(s10_v_r), .a_i(s10_r.x), .side_i(s10_r),
    .v_o(q1_v), .root_o(q1_root), .side_o(q1_side)
  );

  always_comb begin
    s11_nxt   = ctx_t'(q1_side);
    s11_nxt.x = q1_root;
    s11_nxt.y = q1_root;
  end

  cfr_sqrt #(.WORD_W(W), .FRAC_W(F), .SIDE_W(CTX_W)) u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .v_i(s11_v_r), .a_i(s11_r.x), .side_i(s11_r),
    .v_o(q2_v), .root_o(q2_root), .side_o(q2_side)
  );

  // final product: h*r4, or p*h*f
  ctx_t         q2_c;
  logic [W-1:0] f_val, fin_val;
  logic         fin_sat;
  always_comb begin
    q2_c = ctx_t'(q2_side);
    case (mode_r)
      MODE_LINEAR: f_val = q2_c.k;
      MODE_SQRT:   f_val = q2_c.y;
      default:     f_val = q2_root;
    endcase
    if (an) begin
      {fin_sat, fin_val} = qmul(q2_c.h, q2_root);
    end else begin
      {fin_sat, fin_val} = qmul(q2_c.ph, f_val);
    end
    s12_nxt     = q2_c;
    s12_nxt.x   = fin_val;
    s12_nxt.sat = q2_c.sat | fin_sat;
  end

  // add m outside the analytic law, resolve fallbacks, fit the 32-bit field
  logic [W:0]    rsum;
  logic [W-1:0]  r_val;
  logic          r_sat, big;
  logic [XW-1:0] rx, mx;
  always_comb begin
    rsum  = {1'b0, cm} + {1'b0, s12_r.x};
    r_sat = 1'b0;
    if (an) begin
      r_val = s12_r.dk0 ? WMAX : s12_r.x;
    end else begin
      r_sat = rsum[W];
      r_val = rsum[W] ? WMAX : rsum[W-1:0];
    end
    rx  = XW'(r_val);
    mx  = XW'(cm);
    big = rx > XW'(32'hFFFF_FFFF);
    if (s12_r.fb) begin
      out_nxt.radius = mx[31:0];
      out_nxt.status = s12_r.zdiv ? STATUS_ZDIV : STATUS_OK;
    end else begin
      out_nxt.radius = big ? 32'hFFFF_FFFF : rx[31:0];
      out_nxt.status = (s12_r.sat | r_sat | cfg_sat | s12_r.dk0 | big) ? STATUS_SAT
                                                                       : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      s11_v_r <= 1'b0;
      s12_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= start & ~busy;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= d1_v;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= d2_v;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= d3_v;
      s10_v_r <= d4_v;
      s11_v_r <= q1_v;
      s12_v_r <= q2_v;
      out_v_r <= s12_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    s4_r  <= s4_nxt;
    s5_r  <= s5_nxt;
    s6_r  <= s6_nxt;
    s7_r  <= s7_nxt;
    s8_r  <= s8_nxt;
    s9_r  <= s9_nxt;
    s10_r <= s10_nxt;
    s11_r <= s11_nxt;
    s12_r <= s12_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> s1_v_r)
    else $error("accepted beat did not enter the pipeline");

  a_last_stage_out: assert property (@(posedge clk) disable iff (!rst_n)
    s12_v_r |=> out_valid)
    else $error("last stage beat did not reach the output");

  a_zdiv_is_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    s12_v_r |-> (!s12_r.zdiv || s12_r.fb))
    else $error("zero divisor flagged without fallback");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_ZDIV ||
                   out_data.status == STATUS_SAT))
    else $error("undefined status code on output beat");
`endif

endmodule
